### rtl/sbs_pkg.sv
// Shared constants, widths and saturation helper for the shell bending stencil.
package sbs_pkg;

   localparam int MAX_EDGES   = 1024;
   localparam int FRAC_BITS   = 16;
   localparam int EIDX_W      = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int STORE_DEPTH = 16 * MAX_EDGES;
   localparam int STORE_AW    = EIDX_W + 4;
   localparam int PROD_W      = 66;
   localparam int ACC_W       = PROD_W - FRAC_BITS + 2;
   localparam int DIV_W       = 33 + FRAC_BITS;
   localparam int DCNT_W      = $clog2(DIV_W + 1);
   localparam int SAT_W       = 72;

   localparam logic MODE_ASSEMBLE = 1'b0;
   localparam logic MODE_APPLY    = 1'b1;

   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   // clamp a wide signed value to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
      logic hi_ones;
      logic hi_zeros;
      hi_ones  = &v[SAT_W-1:31];
      hi_zeros = ~|v[SAT_W-1:31];
      if (hi_ones || hi_zeros) begin
         return v[31:0];
      end else if (v[SAT_W-1]) begin
         return Q_MIN;
      end else begin
         return Q_MAX;
      end
   endfunction

endpackage

### rtl/sbs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/shell_bending_stencil.sv
// Top level: per-edge bending stiffness assembly and force application.
//
//   channel  dir  handshake           payload
//   req      in   req_valid/stall     mode, edge_index, vertex_slot, is_boundary, pos_x/y/z
//   rsp      out  rsp_valid/stall     out_slot, force_x/y/z, last
//   csr      in   csr_wr_en           csr_wr_data (bend_coeff)
//
// A completing assemble transaction computes four cotangents through one shared
// multiplier, a 32-step square root and a shift-subtract divider, then 16 matrix
// entries, each with a divide, written one per entry into the stiffness RAM. A
// completing apply transaction makes four RAM reads and twelve multiplies per force
// and waits in its output state while rsp is stalled.
// req_stall is high while a flap is being processed. Synchronous active-high reset.
module shell_bending_stencil
   import sbs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [31:0]        csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_mode,
   input  logic [9:0]         req_edge_index,
   input  logic [1:0]         req_vertex_slot,
   input  logic               req_is_boundary,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_out_slot,
   output logic signed [31:0] rsp_force_x,
   output logic signed [31:0] rsp_force_y,
   output logic signed [31:0] rsp_force_z,
   output logic               rsp_last
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_VEC, ST_MUL, ST_ACC, ST_SQRT, ST_DIV, ST_COT, ST_CW,
      ST_MAT_MUL, ST_MAT_T, ST_MAT_SCALE, ST_MAT_WR,
      ST_AP_RD, ST_AP_MUL, ST_AP_ACC, ST_AP_OUT
   } state_type;

   state_type state_ff;

   logic [31:0]        bend_ff;
   logic [3:0]         seen_ff;
   logic signed [31:0] hold_ff [4][3];
   logic [9:0]         edge_ff;

   logic [1:0]         cot_ff;
   logic [3:0]         mstep_ff;
   logic signed [31:0] e1_ff [3];
   logic signed [31:0] e2_ff [3];
   logic signed [31:0] n_ff [3];
   logic signed [PROD_W-1:0] xt_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  dot_ff;
   logic [63:0]        s_ff;
   logic [63:0]        sq_v_ff;
   logic [63:0]        sq_r_ff;
   logic [63:0]        sq_b_ff;
   logic signed [31:0] cotv_ff [4];
   logic signed [31:0] c_ff [4];
   logic signed [31:0] area_ff;
   logic [3:0]         ij_ff;

   logic [DIV_W-1:0]   div_dvd_ff;
   logic [31:0]        div_rem_ff;
   logic [31:0]        div_dmag_ff;
   logic [DCNT_W-1:0]  div_cnt_ff;
   logic               div_neg_ff;
   logic               div_zero_ff;
   logic               div_nsign_ff;
   logic               div_nnz_ff;
   logic               div_mat_ff;

   logic [1:0]         ai_ff;
   logic [1:0]         aj_ff;
   logic [1:0]         k_ff;
   logic signed [ACC_W-1:0] acc_ff [3];

   logic               rsp_valid_ff;
   logic [1:0]         rsp_slot_ff;
   logic signed [31:0] rsp_fx_ff;
   logic signed [31:0] rsp_fy_ff;
   logic signed [31:0] rsp_fz_ff;
   logic               rsp_last_ff;

   // combinational helpers
   logic signed [32:0] mul_a;
   logic signed [32:0] mul_b;
   logic [1:0]         va, vb, vc;
   logic [63:0]        sq_sum;
   logic signed [31:0] norm;
   logic signed [31:0] mat_t;
   logic signed [31:0] mat_t3;
   logic signed [31:0] div_num;
   logic signed [31:0] div_den;
   logic [32:0]        num_abs;
   logic [32:0]        den_abs;
   logic [32:0]        rem2;
   logic               div_ge;
   logic [32:0]        rem_nx;
   logic signed [SAT_W-1:0] q_ext;
   logic signed [31:0] div_q;
   logic [3:0]         seen_nx;
   logic               out_free;

   logic                ram_wr_en;
   logic [STORE_AW-1:0] ram_wr_addr;
   logic [31:0]         ram_wr_data;
   logic                ram_rd_en;
   logic [STORE_AW-1:0] ram_rd_addr;
   logic [31:0]         ram_rd_data;

   sbs_ram #(
      .WIDTH (32),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_slot = rsp_slot_ff;
   assign rsp_force_x  = rsp_fx_ff;
   assign rsp_force_y  = rsp_fy_ff;
   assign rsp_force_z  = rsp_fz_ff;
   assign rsp_last     = rsp_last_ff;
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   assign seen_nx = seen_ff | (4'b0001 << req_vertex_slot);

   assign ram_wr_en   = (state_ff == ST_MAT_WR);
   assign ram_wr_addr = {EIDX_W'(edge_ff), ij_ff};
   assign ram_wr_data = sat32(SAT_W'(prod_ff >>> FRAC_BITS));
   assign ram_rd_en   = (state_ff == ST_AP_RD);
   assign ram_rd_addr = {EIDX_W'(edge_ff), ai_ff, aj_ff};

   // vertex triple (apex, two ends) of each cotangent
   always_comb begin
      case (cot_ff)
         2'd0:    begin va = 2'd0; vb = 2'd1; vc = 2'd2; end
         2'd1:    begin va = 2'd0; vb = 2'd3; vc = 2'd1; end
         2'd2:    begin va = 2'd1; vb = 2'd2; vc = 2'd0; end
         default: begin va = 2'd1; vb = 2'd0; vc = 2'd3; end
      endcase
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MUL: begin
            case (mstep_ff)
               4'd0:  begin mul_a = 33'(e1_ff[0]); mul_b = 33'(e2_ff[0]); end
               4'd1:  begin mul_a = 33'(e1_ff[1]); mul_b = 33'(e2_ff[1]); end
               4'd2:  begin mul_a = 33'(e1_ff[2]); mul_b = 33'(e2_ff[2]); end
               4'd3:  begin mul_a = 33'(e1_ff[1]); mul_b = 33'(e2_ff[2]); end
               4'd4:  begin mul_a = 33'(e1_ff[2]); mul_b = 33'(e2_ff[1]); end
               4'd5:  begin mul_a = 33'(e1_ff[2]); mul_b = 33'(e2_ff[0]); end
               4'd6:  begin mul_a = 33'(e1_ff[0]); mul_b = 33'(e2_ff[2]); end
               4'd7:  begin mul_a = 33'(e1_ff[0]); mul_b = 33'(e2_ff[1]); end
               4'd8:  begin mul_a = 33'(e1_ff[1]); mul_b = 33'(e2_ff[0]); end
               4'd9:  begin mul_a = 33'(n_ff[0]);  mul_b = 33'(n_ff[0]);  end
               4'd10: begin mul_a = 33'(n_ff[1]);  mul_b = 33'(n_ff[1]);  end
               4'd11: begin mul_a = 33'(n_ff[2]);  mul_b = 33'(n_ff[2]);  end
               default: ;
            endcase
         end
         ST_MAT_MUL: begin
            mul_a = 33'(c_ff[ij_ff[3:2]]);
            mul_b = 33'(c_ff[ij_ff[1:0]]);
         end
         ST_MAT_SCALE: begin
            mul_a = 33'(div_q);
            mul_b = {1'b0, bend_ff};
         end
         ST_AP_MUL: begin
            mul_a = 33'($signed(ram_rd_data));
            mul_b = 33'(hold_ff[aj_ff][k_ff]);
         end
         default: ;
      endcase
   end

   // square root step, divider step and result
   always_comb begin
      sq_sum = sq_r_ff + sq_b_ff;
      norm   = (|sq_r_ff[63:31]) ? Q_MAX : $signed(sq_r_ff[31:0]);
      mat_t  = sat32(SAT_W'(prod_ff >>> FRAC_BITS));
      mat_t3 = sat32((SAT_W'(mat_t) + (SAT_W'(mat_t) <<< 1)) >>> 1);
      if (state_ff == ST_MAT_T) begin
         div_num = mat_t3;
         div_den = area_ff;
      end else begin
         div_num = sat32(SAT_W'(dot_ff));
         div_den = norm;
      end
      num_abs = div_num[31] ? (33'd0 - 33'(div_num)) : 33'(div_num);
      den_abs = div_den[31] ? (33'd0 - 33'(div_den)) : 33'(div_den);
      rem2    = {div_rem_ff, div_dvd_ff[DIV_W-1]};
      div_ge  = (rem2 >= {1'b0, div_dmag_ff});
      rem_nx  = div_ge ? (rem2 - {1'b0, div_dmag_ff}) : rem2;
      q_ext   = div_neg_ff ? (SAT_W'(0) - SAT_W'(div_dvd_ff)) : SAT_W'(div_dvd_ff);
      if (div_zero_ff) begin
         div_q = !div_nnz_ff ? 32'sd0 : (div_nsign_ff ? Q_MIN : Q_MAX);
      end else begin
         div_q = sat32(q_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bend_ff      <= '0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            bend_ff <= csr_wr_data;
         end
         // the output state loads its own transaction
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_AP_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         prod_ff <= mul_a * mul_b;

         case (state_ff)
            ST_IDLE: begin
               if (req_valid && !req_is_boundary) begin
                  hold_ff[req_vertex_slot][0] <= req_pos_x;
                  hold_ff[req_vertex_slot][1] <= req_pos_y;
                  hold_ff[req_vertex_slot][2] <= req_pos_z;
                  if (seen_nx == 4'hF) begin
                     seen_ff <= '0;
                     edge_ff <= req_edge_index;
                     cot_ff  <= '0;
                     ai_ff   <= '0;
                     aj_ff   <= '0;
                     k_ff    <= '0;
                     for (int k = 0; k < 3; k++) begin
                        acc_ff[k] <= '0;
                     end
                     if (32'(req_edge_index) < MAX_EDGES) begin
                        state_ff <= (req_mode == MODE_APPLY) ? ST_AP_RD : ST_VEC;
                     end
                  end else begin
                     seen_ff <= seen_nx;
                  end
               end
            end

            ST_VEC: begin
               for (int k = 0; k < 3; k++) begin
                  e1_ff[k] <= sat32(SAT_W'(hold_ff[vb][k]) - SAT_W'(hold_ff[va][k]));
                  e2_ff[k] <= sat32(SAT_W'(hold_ff[vc][k]) - SAT_W'(hold_ff[va][k]));
               end
               dot_ff   <= '0;
               s_ff     <= '0;
               mstep_ff <= '0;
               state_ff <= ST_MUL;
            end

            ST_MUL: begin
               state_ff <= ST_ACC;
            end

            ST_ACC: begin
               case (mstep_ff)
                  4'd0, 4'd1, 4'd2: dot_ff <= dot_ff + ACC_W'(prod_ff >>> FRAC_BITS);
                  4'd3, 4'd5, 4'd7: xt_ff <= prod_ff;
                  4'd4: n_ff[0] <= sat32((SAT_W'(xt_ff) - SAT_W'(prod_ff)) >>> FRAC_BITS);
                  4'd6: n_ff[1] <= sat32((SAT_W'(xt_ff) - SAT_W'(prod_ff)) >>> FRAC_BITS);
                  4'd8: n_ff[2] <= sat32((SAT_W'(xt_ff) - SAT_W'(prod_ff)) >>> FRAC_BITS);
                  4'd9, 4'd10: s_ff <= s_ff + prod_ff[63:0];
                  4'd11: begin
                     sq_v_ff <= s_ff + prod_ff[63:0];
                     sq_r_ff <= '0;
                     sq_b_ff <= 64'h4000_0000_0000_0000;
                  end
                  default: ;
               endcase
               if (mstep_ff == 4'd11) begin
                  state_ff <= ST_SQRT;
               end else begin
                  mstep_ff <= mstep_ff + 4'd1;
                  state_ff <= ST_MUL;
               end
            end

            ST_SQRT: begin
               if (sq_b_ff == '0) begin
                  if (cot_ff == 2'd0) begin
                     area_ff <= {1'b0, norm[31:1]};
                  end else if (cot_ff == 2'd3) begin
                     area_ff <= area_ff + {1'b0, norm[31:1]};
                  end
                  div_dvd_ff   <= {num_abs, FRAC_BITS'(0)};
                  div_dmag_ff  <= den_abs[31:0];
                  div_rem_ff   <= '0;
                  div_cnt_ff   <= DCNT_W'(DIV_W);
                  div_neg_ff   <= div_num[31] ^ div_den[31];
                  div_zero_ff  <= (div_den == 32'sd0);
                  div_nsign_ff <= div_num[31];
                  div_nnz_ff   <= |div_num;
                  div_mat_ff   <= 1'b0;
                  state_ff     <= ST_DIV;
               end else begin
                  if (sq_v_ff >= sq_sum) begin
                     sq_v_ff <= sq_v_ff - sq_sum;
                     sq_r_ff <= (sq_r_ff >> 1) + sq_b_ff;
                  end else begin
                     sq_r_ff <= sq_r_ff >> 1;
                  end
                  sq_b_ff <= sq_b_ff >> 2;
               end
            end

            ST_DIV: begin
               if (div_zero_ff || div_cnt_ff == '0) begin
                  state_ff <= div_mat_ff ? ST_MAT_SCALE : ST_COT;
               end else begin
                  div_rem_ff <= rem_nx[31:0];
                  div_dvd_ff <= {div_dvd_ff[DIV_W-2:0], div_ge};
                  div_cnt_ff <= div_cnt_ff - DCNT_W'(1);
               end
            end

            ST_COT: begin
               cotv_ff[cot_ff] <= div_q;
               if (cot_ff == 2'd3) begin
                  state_ff <= ST_CW;
               end else begin
                  cot_ff   <= cot_ff + 2'd1;
                  state_ff <= ST_VEC;
               end
            end

            ST_CW: begin
               c_ff[0]  <= sat32(SAT_W'(cotv_ff[2]) + SAT_W'(cotv_ff[3]));
               c_ff[1]  <= sat32(SAT_W'(cotv_ff[0]) + SAT_W'(cotv_ff[1]));
               c_ff[2]  <= sat32(SAT_W'(0) - SAT_W'(cotv_ff[0]) - SAT_W'(cotv_ff[2]));
               c_ff[3]  <= sat32(SAT_W'(0) - SAT_W'(cotv_ff[1]) - SAT_W'(cotv_ff[3]));
               ij_ff    <= '0;
               state_ff <= ST_MAT_MUL;
            end

            ST_MAT_MUL: begin
               state_ff <= ST_MAT_T;
            end

            ST_MAT_T: begin
               div_dvd_ff   <= {num_abs, FRAC_BITS'(0)};
               div_dmag_ff  <= den_abs[31:0];
               div_rem_ff   <= '0;
               div_cnt_ff   <= DCNT_W'(DIV_W);
               div_neg_ff   <= div_num[31] ^ div_den[31];
               div_zero_ff  <= (div_den == 32'sd0);
               div_nsign_ff <= div_num[31];
               div_nnz_ff   <= |div_num;
               div_mat_ff   <= 1'b1;
               state_ff     <= ST_DIV;
            end

            ST_MAT_SCALE: begin
               state_ff <= ST_MAT_WR;
            end

            ST_MAT_WR: begin
               ij_ff    <= ij_ff + 4'd1;
               state_ff <= (ij_ff == 4'hF) ? ST_IDLE : ST_MAT_MUL;
            end

            ST_AP_RD: begin
               k_ff     <= '0;
               state_ff <= ST_AP_MUL;
            end

            ST_AP_MUL: begin
               state_ff <= ST_AP_ACC;
            end

            ST_AP_ACC: begin
               acc_ff[k_ff] <= acc_ff[k_ff] + ACC_W'(prod_ff >>> FRAC_BITS);
               if (k_ff == 2'd2) begin
                  if (aj_ff == 2'd3) begin
                     state_ff <= ST_AP_OUT;
                  end else begin
                     aj_ff    <= aj_ff + 2'd1;
                     state_ff <= ST_AP_RD;
                  end
               end else begin
                  k_ff     <= k_ff + 2'd1;
                  state_ff <= ST_AP_MUL;
               end
            end

            ST_AP_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_slot_ff  <= ai_ff;
                  rsp_fx_ff    <= sat32(SAT_W'(acc_ff[0]));
                  rsp_fy_ff    <= sat32(SAT_W'(acc_ff[1]));
                  rsp_fz_ff    <= sat32(SAT_W'(acc_ff[2]));
                  rsp_last_ff  <= (ai_ff == 2'd3);
                  for (int k = 0; k < 3; k++) begin
                     acc_ff[k] <= '0;
                  end
                  aj_ff <= '0;
                  if (ai_ff == 2'd3) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     ai_ff    <= ai_ff + 2'd1;
                     state_ff <= ST_AP_RD;
                  end
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
